/* hdl/bdlq_pkg.sv */
// Shared constants, codes and types of the button debounce and event queue block.
package bdlq_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int RING_DEPTH  = 8;
  localparam int TIME_BITS   = 32;

  localparam int NOW_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CODE_W    = 3;
  localparam int LEVEL_W   = 3;
  localparam int PTR_W     = $clog2(RING_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = CFG_W'(20);
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(800);

  // request operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // event codes: short press of button i is SHORT_BASE + i, long press LONG_BASE + i
  localparam logic [CODE_W-1:0] EVT_NONE = CODE_W'(0);
  localparam int EVT_SHORT_BASE = 1;
  localparam int EVT_LONG_BASE  = 4;

  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } btn_hit_t;

endpackage

/* hdl/bdlq_if.sv */
// Request and response channel interfaces of the button event block.
interface bdlq_req_if import bdlq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [2:0]        pressed_bits;
  logic [NOW_W-1:0]  now_ms;

  modport source (output valid, op, pressed_bits, now_ms, input ready);
  modport sink   (input valid, op, pressed_bits, now_ms, output ready);
endinterface

interface bdlq_rsp_if import bdlq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  event_code;
  logic [LEVEL_W-1:0] queue_level;

  modport source (output valid, event_code, queue_level, input ready);
  modport sink   (input valid, event_code, queue_level, output ready);
endinterface

/* hdl/bdlq_button.sv */
// Debounce and press timing for one button.
module bdlq_button import bdlq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 raw_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [CFG_W-1:0]     dbw_i,
  input  logic [CFG_W-1:0]     lpt_i,
  output btn_hit_t             hit_o
);

  logic                 raw_q, raw_d;
  logic                 stable_q, stable_d;
  logic                 long_q, long_d;
  logic [TIME_BITS-1:0] chg_q, chg_d;
  logic [TIME_BITS-1:0] press_q, press_d;
  logic                 settled;
  btn_hit_t             hit;

  always_comb begin
    raw_d    = raw_i;
    chg_d    = (raw_i != raw_q) ? now_i : chg_q;
    settled  = (now_i - chg_d) >= TIME_BITS'(dbw_i);
    stable_d = stable_q;
    press_d  = press_q;
    long_d   = long_q;
    hit      = '0;
    if (settled) begin
      stable_d = raw_i;
      if (!stable_q && raw_i) begin
        press_d = now_i;
        long_d  = 1'b0;
      end
      hit.short_hit = stable_q & ~raw_i & ~long_q;
      // press timer runs from the (possibly just taken) press time
      if (raw_i && !long_d && ((now_i - press_d) >= TIME_BITS'(lpt_i))) begin
        long_d       = 1'b1;
        hit.long_hit = 1'b1;
      end
    end
  end

  assign hit_o.short_hit = en_i & hit.short_hit;
  assign hit_o.long_hit  = en_i & hit.long_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      long_q   <= 1'b0;
      chg_q    <= '0;
      press_q  <= '0;
    end else if (en_i) begin
      raw_q    <= raw_d;
      stable_q <= stable_d;
      long_q   <= long_d;
      chg_q    <= chg_d;
      press_q  <= press_d;
    end
  end

endmodule

/* hdl/bdlq_ring.sv */
// Event ring: up to one push per button and one pop per request, one slot kept free.
module bdlq_ring import bdlq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_en_i,
  input  btn_hit_t [NUM_BUTTONS-1:0] hit_i,
  output logic [CODE_W-1:0]        code_o,
  output logic [PTR_W-1:0]         level_o
);

  logic [CODE_W-1:0] ring_q [RING_DEPTH];
  logic [CODE_W-1:0] ring_d [RING_DEPTH];
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [PTR_W:0]    lvl;
  logic [CODE_W-1:0] code;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    ring_d = ring_q;
    wp_d   = wp_q;
    rp_d   = rp_q;
    code   = EVT_NONE;
    lvl    = (PTR_W + 1)'(wp_q) + (PTR_W + 1)'(RING_DEPTH) - (PTR_W + 1)'(rp_q);
    if (lvl >= (PTR_W + 1)'(RING_DEPTH)) begin
      lvl = lvl - (PTR_W + 1)'(RING_DEPTH);
    end
    // buttons in order; a push into a full ring is dropped
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if ((hit_i[i].short_hit || hit_i[i].long_hit) &&
          (lvl < (PTR_W + 1)'(RING_DEPTH - 1))) begin
        ring_d[wp_d] = hit_i[i].short_hit ? CODE_W'(i + EVT_SHORT_BASE)
                                          : CODE_W'(i + EVT_LONG_BASE);
        wp_d = ptr_next(wp_d);
        lvl  = lvl + 1'b1;
      end
    end
    if (pop_en_i && (lvl != '0)) begin
      code = ring_q[rp_q];
      rp_d = ptr_next(rp_q);
      lvl  = lvl - 1'b1;
    end
  end

  assign code_o  = code;
  assign level_o = lvl[PTR_W-1:0];

  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

endmodule

/* hdl/button_debounce_long_press_queue_unit.sv */
// Three-button debouncer with short/long press events and an event queue. Each request
// is either a sample (op 0: raw pressed bits plus a millisecond timestamp) or a pop
// (op 1: take the oldest event). A request is registered in the request register on
// acceptance, processed from there and its result registered in the response register,
// so one request is accepted every clock cycle while the response side is ready;
// while a response waits the input register holds one further request and then lowers ready.
// The response carries the event code (0 on samples and on an empty pop) and the
// number of events left.
// The queue holds seven events; events raised while it is full are lost. Buttons start
// released and the two timing registers may be rewritten only while the block is idle.
module button_debounce_long_press_queue_unit import bdlq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bdlq_req_if.sink             req_i,
  bdlq_rsp_if.source           rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [CFG_W-1:0]     dbw_q, lpt_q;

  logic                 s1_valid_q;
  logic                 s1_op_q;
  logic [2:0]           s1_bits_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic                 s1_go;
  logic                 in_ready;
  logic                 sample_en;

  logic                 out_valid_q;
  logic [CODE_W-1:0]    out_code_q;
  logic [LEVEL_W-1:0]   out_lvl_q;
  logic [PTR_W-1:0]     level_q;

  btn_hit_t [NUM_BUTTONS-1:0] hits;
  logic [CODE_W-1:0]    ring_code;
  logic [PTR_W-1:0]     ring_level;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbw_q <= DEBOUNCE_RESET;
      lpt_q <= LONG_PRESS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:   dbw_q <= cfg_wdata_i;
        CFG_LONG_PRESS: lpt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s1_go     = s1_valid_q & (~out_valid_q | rsp_o.ready);
  assign in_ready  = ~s1_valid_q | s1_go;
  assign sample_en = s1_go & (s1_op_q == OP_SAMPLE);
  assign req_i.ready = in_ready;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      s1_op_q   <= req_i.op;
      s1_bits_q <= req_i.pressed_bits;
      s1_now_q  <= req_i.now_ms[TIME_BITS-1:0];
    end
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    logic raw;
    if (g < 3) begin : g_in
      assign raw = s1_bits_q[g];
    end else begin : g_none
      assign raw = 1'b0;
    end
    bdlq_button u_button (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (sample_en),
      .raw_i  (raw),
      .now_i  (s1_now_q),
      .dbw_i  (dbw_q),
      .lpt_i  (lpt_q),
      .hit_o  (hits[g])
    );
  end

  bdlq_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pop_en_i (s1_go & (s1_op_q == OP_POP)),
    .hit_i    (hits),
    .code_o   (ring_code),
    .level_o  (ring_level)
  );

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      level_q     <= '0;
    end else begin
      if (s1_go) begin
        out_valid_q <= 1'b1;
        level_q     <= ring_level;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_code_q <= ring_code;
      out_lvl_q  <= LEVEL_W'(ring_level);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.event_code  = out_code_q;
  assign rsp_o.queue_level = out_lvl_q;

`ifndef ASSERT_OFF
  a_sample_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_op_q == OP_SAMPLE)) |=> (out_code_q == EVT_NONE))
    else $error("sample request returned an event code");

  a_pop_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_op_q == OP_POP)) |-> ((ring_code == EVT_NONE) == (level_q == '0)))
    else $error("pop result disagrees with queue level");

  a_sample_no_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_op_q == OP_SAMPLE)) |-> (ring_level >= level_q))
    else $error("queue shrank on a sample request");
`endif

endmodule
